>>> rtl/rgbw_pkg.sv
// rgbw_pkg: shared types, codes and constants of the RGBW LED animation driver.
// Holds the cosine table generator used at elaboration and the small arithmetic helpers.
// No dependencies.
`default_nettype none

package rgbw_pkg;

  // default number of phase steps in one animation period
  localparam int STEPS_PER_PERIOD_DEF = 200;

  // configuration register indexes
  localparam logic [1:0] REG_MODE     = 2'd0;
  localparam logic [1:0] REG_COLOR    = 2'd1;
  localparam logic [1:0] REG_INTERVAL = 2'd2;

  localparam int          CFG_DATA_W     = 10;
  localparam logic [9:0]  INTERVAL_RESET = 10'd10;

  typedef enum logic [1:0] {
    MODE_SOLID   = 2'd0,
    MODE_PULSE   = 2'd1,
    MODE_RAINBOW = 2'd2,
    MODE_OFF     = 2'd3
  } mode_t;

  // colour codes; code seven falls back to red
  localparam logic [2:0] COLOR_RED     = 3'd0;
  localparam logic [2:0] COLOR_YELLOW  = 3'd1;
  localparam logic [2:0] COLOR_GREEN   = 3'd2;
  localparam logic [2:0] COLOR_CYAN    = 3'd3;
  localparam logic [2:0] COLOR_BLUE    = 3'd4;
  localparam logic [2:0] COLOR_MAGENTA = 3'd5;
  localparam logic [2:0] COLOR_WHITE   = 3'd6;

  // duty channel codes
  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_CHECK = 3'd1,
    ST_READ  = 3'd2,
    ST_DRAIN = 3'd3,
    ST_EMIT  = 3'd4
  } state_t;

  // cycles from the last table read until its duty is stored
  localparam int         DP_DRAIN   = 3;
  localparam logic [1:0] DRAIN_LAST = 2'(DP_DRAIN - 1);

  // full-on colour at 95 percent
  localparam logic [7:0] SOLID_DUTY = 8'((255 * 95) / 100);

  // pulse scaling: 100 times (0.47*cos + 0.48) in Q15
  localparam logic signed [22:0] PULSE_GAIN   = 23'sd47;
  localparam logic signed [22:0] PULSE_OFFSET = 23'sd1572864;
  localparam logic signed [17:0] COS_BIAS     = 18'sd32768;
  localparam logic [14:0]        RAINBOW_PCT  = 15'd95;

  // floor(y/100) for y below 43690: multiply by 5243 / 2^19
  localparam logic [27:0] DIV100_RECIP = 28'd5243;

  // Q30 constants of the cosine generator
  localparam longint Q30_ONE     = 64'sd1073741824;
  localparam longint PI_Q30      = 64'sd3373259426;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint TWO_PI_Q30  = 64'sd6746518852;
  localparam longint TAYLOR_DIV [6] = '{64'sd132, 64'sd90, 64'sd56, 64'sd30, 64'sd12, 64'sd2};

  typedef struct packed {
    mode_t       mode;
    logic [2:0]  color;
    logic [9:0]  interval;
  } cfg_t;

  typedef struct packed {
    logic        load_now;  // capture the timestamp word
    logic        commit;    // due: advance phase, white and due time
    logic        rd_valid;  // cosine table read this cycle
    logic [1:0]  rd_ch;     // channel of that read
    logic        emit;      // load the output register
  } dp_cmd_t;

  typedef struct packed {
    logic        due;
  } dp_sts_t;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  white;
  } duty_t;

  // channel mask of a colour, bit 0 red .. bit 3 white
  function automatic logic [3:0] color_mask(input logic [2:0] color);
    logic [3:0] m;
    unique case (color)
      COLOR_RED:     m = 4'b0001;
      COLOR_YELLOW:  m = 4'b0011;
      COLOR_GREEN:   m = 4'b0010;
      COLOR_CYAN:    m = 4'b0110;
      COLOR_BLUE:    m = 4'b0100;
      COLOR_MAGENTA: m = 4'b0101;
      COLOR_WHITE:   m = 4'b1000;
      default:       m = 4'b0001;
    endcase
    return m;
  endfunction

  function automatic logic [7:0] div100(input logic [14:0] y);
    logic [27:0] prod;
    prod = 28'(y) * DIV100_RECIP;
    return prod[26:19];
  endfunction

  // Q15 cosine of a Q30 angle in [0, 2pi): Taylor series on the first quadrant,
  // clamped to [0, 1], rounded half up, sign from symmetry. Elaboration only.
  function automatic logic signed [16:0] cos_from_theta(input longint theta);
    longint th;
    longint x2;
    longint p;
    logic   neg;
    th  = theta;
    neg = 1'b0;
    if (th > PI_Q30) begin
      th = TWO_PI_Q30 - th;
    end
    if (th > HALF_PI_Q30) begin
      th  = PI_Q30 - th;
      neg = 1'b1;
    end
    x2 = (th * th) / Q30_ONE;
    p  = Q30_ONE;
    for (int i = 0; i < 6; i++) begin
      p = Q30_ONE - ((x2 * p) / Q30_ONE) / TAYLOR_DIV[i];
    end
    if (p < 0) begin
      p = 0;
    end
    if (p > Q30_ONE) begin
      p = Q30_ONE;
    end
    p = (p + 64'sd16384) / 64'sd32768;
    return neg ? 17'(-p) : 17'(p);
  endfunction

endpackage

`default_nettype wire

>>> rtl/rgbw_in_if.sv
// rgbw_in_if: timestamp input channel, valid/ready handshake.
// No dependencies.
`default_nettype none

interface rgbw_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] now_ms;

  modport source (output valid, output now_ms, input ready);
  modport sink   (input valid, input now_ms, output ready);
endinterface

`default_nettype wire

>>> rtl/rgbw_out_if.sv
// rgbw_out_if: duty result channel, valid/ready handshake.
// No dependencies.
`default_nettype none

interface rgbw_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_duty;
  logic [7:0] green_duty;
  logic [7:0] blue_duty;
  logic [7:0] white_duty;

  modport source (output valid, output red_duty, output green_duty, output blue_duty,
                  output white_duty, input ready);
  modport sink   (input valid, input red_duty, input green_duty, input blue_duty,
                  input white_duty, output ready);
endinterface

`default_nettype wire

>>> rtl/rgbw_cfg_if.sv
// rgbw_cfg_if: configuration write channel, register index plus data.
// No dependencies.
`default_nettype none

interface rgbw_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [9:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/rgbw_led_animation_driver.sv
// RGBW LED animation driver, top level.
// Channels: in_chan carries a millisecond timestamp word; out_chan carries four 8-bit
// PWM duties (red, green, blue, white); cfg_chan writes mode (0), colour (1) and update
// interval (2). All use valid/ready; a word moves when both are high.
// A timestamp at or past the stored due time yields one duty word and moves the due
// time to timestamp plus interval; an earlier timestamp yields nothing.
// From accept to out valid: solid and off go from the check step straight to emit;
// pulse and rainbow first read the cosine table and drain the scaling pipe. A timestamp
// that is not due frees the input after the check step. The next timestamp is taken
// once the word has reached the output register, so no timestamp is taken while the
// last is still in work. The steps per item are one cosine table read per channel used
// (red only in pulse, every colour channel in rainbow) plus a three-stage scaling pipe.
// The output register holds a word until taken; a stalled receiver holds the block in
// its emit step, while one waiting word does not stop the next timestamp being taken.
// Reset (rst_n low, synchronous): mode solid, colour red, interval 10 ms, due time 0,
// phase 0, white memory cleared, no word pending. No clearing pass is needed.
// Depends on rgbw_pkg, the three channel interfaces, rgbw_cfg, rgbw_ctrl and rgbw_dp.
`default_nettype none

module rgbw_led_animation_driver #(
  parameter int STEPS_PER_PERIOD = rgbw_pkg::STEPS_PER_PERIOD_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  rgbw_in_if.sink    in_chan,
  rgbw_out_if.source out_chan,
  rgbw_cfg_if.sink   cfg_chan
);

  rgbw_pkg::cfg_t    cfg;
  rgbw_pkg::dp_cmd_t cmd;
  rgbw_pkg::dp_sts_t sts;
  rgbw_pkg::duty_t   duty;
  logic              in_ready;
  logic              out_valid;

  // configuration registers
  rgbw_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_chan (cfg_chan),
    .cfg      (cfg)
  );

  // sequencer
  rgbw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .mode      (cfg.mode),
    .in_valid  (in_chan.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_chan.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath
  rgbw_dp #(
    .STEPS_PER_PERIOD (STEPS_PER_PERIOD)
  ) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .now_ms (in_chan.now_ms),
    .cmd    (cmd),
    .sts    (sts),
    .duty   (duty)
  );

  assign in_chan.ready       = in_ready;
  assign out_chan.valid      = out_valid;
  assign out_chan.red_duty   = duty.red;
  assign out_chan.green_duty = duty.green;
  assign out_chan.blue_duty  = duty.blue;
  assign out_chan.white_duty = duty.white;

endmodule

`default_nettype wire

>>> rtl/rgbw_cfg.sv
// rgbw_cfg: configuration register file (mode, colour, update interval).
// Depends on rgbw_pkg and rgbw_cfg_if.
`default_nettype none

module rgbw_cfg (
  input  wire logic          clk,
  input  wire logic          rst_n,
  rgbw_cfg_if.sink           cfg_chan,
  output rgbw_pkg::cfg_t     cfg
);

  rgbw_pkg::cfg_t cfg_r;

  // always able to take a word
  assign cfg_chan.ready = 1'b1;
  assign cfg            = cfg_r;

  // register writes; an unused index is dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode     <= rgbw_pkg::MODE_SOLID;
      cfg_r.color    <= rgbw_pkg::COLOR_RED;
      cfg_r.interval <= rgbw_pkg::INTERVAL_RESET;
    end else if (cfg_chan.valid && cfg_chan.ready) begin
      unique case (cfg_chan.index)
        rgbw_pkg::REG_MODE:     cfg_r.mode     <= rgbw_pkg::mode_t'(cfg_chan.data[1:0]);
        rgbw_pkg::REG_COLOR:    cfg_r.color    <= cfg_chan.data[2:0];
        rgbw_pkg::REG_INTERVAL: cfg_r.interval <= cfg_chan.data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/rgbw_ctrl.sv
// rgbw_ctrl: controller state machine; sequences timestamp check, cosine reads and emit.
// Depends on rgbw_pkg.
`default_nettype none

module rgbw_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire rgbw_pkg::mode_t    mode,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  input  wire rgbw_pkg::dp_sts_t  sts,
  output rgbw_pkg::dp_cmd_t       cmd
);

  rgbw_pkg::state_t state_r, state_nxt;
  logic [1:0] ch_cnt_r, ch_cnt_nxt;
  logic [1:0] drain_cnt_r, drain_cnt_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [1:0] last_ch;
  logic       out_free;

  // rainbow reads three channels, pulse only one
  assign last_ch  = (mode == rgbw_pkg::MODE_RAINBOW) ? rgbw_pkg::CH_BLUE : rgbw_pkg::CH_RED;
  assign out_free = !out_valid_r || out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rgbw_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = rgbw_pkg::ST_CHECK;
      end
      rgbw_pkg::ST_CHECK: begin
        if (!sts.due) begin
          state_nxt = rgbw_pkg::ST_IDLE;
        end else if (mode == rgbw_pkg::MODE_PULSE || mode == rgbw_pkg::MODE_RAINBOW) begin
          state_nxt = rgbw_pkg::ST_READ;
        end else begin
          state_nxt = rgbw_pkg::ST_EMIT;
        end
      end
      rgbw_pkg::ST_READ: begin
        if (ch_cnt_r == last_ch) state_nxt = rgbw_pkg::ST_DRAIN;
      end
      rgbw_pkg::ST_DRAIN: begin
        if (drain_cnt_r == rgbw_pkg::DRAIN_LAST) state_nxt = rgbw_pkg::ST_EMIT;
      end
      rgbw_pkg::ST_EMIT: begin
        if (out_free) state_nxt = rgbw_pkg::ST_IDLE;
      end
      default: state_nxt = rgbw_pkg::ST_IDLE;
    endcase
  end

  // outputs and counters
  always_comb begin
    cmd           = '0;
    in_ready      = 1'b0;
    ch_cnt_nxt    = ch_cnt_r;
    drain_cnt_nxt = drain_cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      rgbw_pkg::ST_IDLE: begin
        in_ready     = 1'b1;
        cmd.load_now = in_valid;
        ch_cnt_nxt   = rgbw_pkg::CH_RED;
      end
      rgbw_pkg::ST_CHECK: begin
        cmd.commit    = sts.due;
        drain_cnt_nxt = '0;
      end
      rgbw_pkg::ST_READ: begin
        cmd.rd_valid = 1'b1;
        cmd.rd_ch    = ch_cnt_r;
        ch_cnt_nxt   = ch_cnt_r + 2'd1;
      end
      rgbw_pkg::ST_DRAIN: begin
        drain_cnt_nxt = drain_cnt_r + 2'd1;
      end
      rgbw_pkg::ST_EMIT: begin
        cmd.emit = out_free;
        if (out_free) out_valid_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rgbw_pkg::ST_IDLE;
      ch_cnt_r    <= '0;
      drain_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ch_cnt_r    <= ch_cnt_nxt;
      drain_cnt_r <= drain_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // an emit never overwrites a word still waiting at the output
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || out_ready))
    else $error("emit while output word pending");

  // channel counter stays within red..blue while reading
  a_ch_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rgbw_pkg::ST_READ) |-> (ch_cnt_r <= rgbw_pkg::CH_BLUE))
    else $error("channel counter out of range");

  // a new result appears only out of the emit state
  a_valid_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == rgbw_pkg::ST_EMIT))
    else $error("result raised outside emit");

endmodule

`default_nettype wire

>>> rtl/rgbw_dp.sv
// rgbw_dp: datapath; due time, phase, cosine table, duty pipeline and output register.
// Depends on rgbw_pkg.
`default_nettype none

module rgbw_dp #(
  parameter int STEPS_PER_PERIOD = rgbw_pkg::STEPS_PER_PERIOD_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire rgbw_pkg::cfg_t     cfg,
  input  wire logic [31:0]        now_ms,
  input  wire rgbw_pkg::dp_cmd_t  cmd,
  output rgbw_pkg::dp_sts_t       sts,
  output rgbw_pkg::duty_t         duty
);

  localparam int WaveLen = 3 * STEPS_PER_PERIOD;
  localparam int PW      = $clog2(STEPS_PER_PERIOD);
  localparam int AW      = $clog2(WaveLen);
  localparam logic [PW:0] StepsW     = (PW + 1)'(STEPS_PER_PERIOD);
  localparam logic [AW:0] WaveLenW   = (AW + 1)'(WaveLen);
  localparam logic [AW:0] OffGreen   = (AW + 1)'(2 * STEPS_PER_PERIOD);
  localparam logic [AW:0] OffBlue    = (AW + 1)'(STEPS_PER_PERIOD);

  logic [31:0]   now_r;
  logic [31:0]   due_r;
  logic [PW-1:0] phase_r;
  logic          white_r;
  logic [3:0]    mask;

  logic signed [16:0] cos_tab [WaveLen];
  logic signed [16:0] cos_r;
  logic [21:0]        a_r;
  logic [14:0]        b_r;
  logic [7:0]         duty_r [3];
  logic [2:0]         tag_v_r;
  logic [1:0]         tag_ch_r [3];
  rgbw_pkg::duty_t    out_r;

  logic [PW:0]        phase_inc;
  logic [AW:0]        addr_off;
  logic [AW:0]        addr_sum;
  logic [AW-1:0]      addr;
  logic signed [22:0] q_s;
  logic signed [17:0] u_s;
  logic [24:0]        lvl_prod;
  logic [21:0]        a_nxt;
  logic [29:0]        pls_prod;
  logic [14:0]        b_nxt;
  rgbw_pkg::duty_t    out_nxt;

  assign mask    = rgbw_pkg::color_mask(cfg.color);
  assign sts.due = (now_r >= due_r);

  // cosine table, one entry per step of three periods
  for (genvar g = 0; g < WaveLen; g++) begin : g_cos
    localparam longint Theta = (longint'(g) * rgbw_pkg::TWO_PI_Q30) / WaveLen;
    assign cos_tab[g] = rgbw_pkg::cos_from_theta(Theta);
  end

  // timestamp capture and per-update state
  assign phase_inc = (PW + 1)'(phase_r) + (PW + 1)'(1);

  always_ff @(posedge clk) begin
    if (cmd.load_now) now_r <= now_ms;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      due_r   <= '0;
      phase_r <= '0;
      white_r <= 1'b0;
    end else if (cmd.commit) begin
      due_r <= now_r + 32'(cfg.interval);
      if (cfg.mode == rgbw_pkg::MODE_PULSE || cfg.mode == rgbw_pkg::MODE_RAINBOW) begin
        phase_r <= (phase_inc >= StepsW) ? '0 : phase_inc[PW-1:0];
      end
      if (cfg.mode == rgbw_pkg::MODE_SOLID || cfg.mode == rgbw_pkg::MODE_PULSE) begin
        white_r <= mask[3];
      end else if (cfg.mode == rgbw_pkg::MODE_OFF) begin
        white_r <= 1'b0;
      end
    end
  end

  // table address: 3*phase plus channel offset, wrapped once
  always_comb begin
    case (cmd.rd_ch)
      rgbw_pkg::CH_GREEN: addr_off = OffGreen;
      rgbw_pkg::CH_BLUE:  addr_off = OffBlue;
      default:            addr_off = '0;
    endcase
    addr_sum = (AW + 1)'(phase_r) * (AW + 1)'(3) + addr_off;
    if (addr_sum >= WaveLenW) begin
      addr_sum = addr_sum - WaveLenW;
    end
    addr = addr_sum[AW-1:0];
  end

  // stage 1: pulse gain or rainbow level
  always_comb begin
    q_s      = 23'(cos_r) * rgbw_pkg::PULSE_GAIN + rgbw_pkg::PULSE_OFFSET;
    u_s      = 18'(cos_r) + rgbw_pkg::COS_BIAS;
    lvl_prod = 25'(u_s[16:0]) * 25'd255;
    a_nxt    = (cfg.mode == rgbw_pkg::MODE_RAINBOW) ? 22'(lvl_prod[23:16]) : q_s[21:0];
  end

  // stage 2: scale to the 100-times duty
  always_comb begin
    pls_prod = 30'(a_r) * 30'd255;
    b_nxt    = (cfg.mode == rgbw_pkg::MODE_RAINBOW) ? 15'(a_r[7:0]) * rgbw_pkg::RAINBOW_PCT
                                                   : pls_prod[29:15];
  end

  // payload pipeline
  always_ff @(posedge clk) begin
    cos_r <= cos_tab[addr];
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    tag_ch_r[0] <= cmd.rd_ch;
    tag_ch_r[1] <= tag_ch_r[0];
    tag_ch_r[2] <= tag_ch_r[1];
  end

  // stage tags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_v_r <= '0;
    end else begin
      tag_v_r <= {tag_v_r[1:0], cmd.rd_valid};
    end
  end

  // stage 3: divide by 100 and store per channel
  always_ff @(posedge clk) begin
    if (tag_v_r[2]) begin
      case (tag_ch_r[2])
        rgbw_pkg::CH_GREEN: duty_r[1] <= rgbw_pkg::div100(b_r);
        rgbw_pkg::CH_BLUE:  duty_r[2] <= rgbw_pkg::div100(b_r);
        default:            duty_r[0] <= rgbw_pkg::div100(b_r);
      endcase
    end
  end

  // result assembly per mode
  always_comb begin
    out_nxt = '0;
    unique case (cfg.mode)
      rgbw_pkg::MODE_SOLID: begin
        out_nxt.red   = mask[0] ? rgbw_pkg::SOLID_DUTY : 8'd0;
        out_nxt.green = mask[1] ? rgbw_pkg::SOLID_DUTY : 8'd0;
        out_nxt.blue  = mask[2] ? rgbw_pkg::SOLID_DUTY : 8'd0;
        out_nxt.white = mask[3] ? rgbw_pkg::SOLID_DUTY : 8'd0;
      end
      rgbw_pkg::MODE_PULSE: begin
        out_nxt.red   = mask[0] ? duty_r[0] : 8'd0;
        out_nxt.green = mask[1] ? duty_r[0] : 8'd0;
        out_nxt.blue  = mask[2] ? duty_r[0] : 8'd0;
        out_nxt.white = mask[3] ? duty_r[0] : 8'd0;
      end
      rgbw_pkg::MODE_RAINBOW: begin
        out_nxt.red   = duty_r[0];
        out_nxt.green = duty_r[1];
        out_nxt.blue  = duty_r[2];
        out_nxt.white = white_r ? rgbw_pkg::SOLID_DUTY : 8'd0;
      end
      default: out_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) out_r <= out_nxt;
  end

  assign duty = out_r;

  // phase stays inside one period
  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    ((PW + 1)'(phase_r) < StepsW))
    else $error("phase out of range");

  // a duty is stored only for a real colour channel
  a_tag_ch: assert property (@(posedge clk) disable iff (!rst_n)
    tag_v_r[2] |-> (tag_ch_r[2] <= rgbw_pkg::CH_BLUE))
    else $error("duty stored for bad channel");

endmodule

`default_nettype wire

>>> tb/rgbw_led_animation_driver_tb.sv
// Testbench for rgbw_led_animation_driver: drives timestamp words, predicts every duty word
// from its own cosine table and animation state, and checks results in order.
// Depends on rgbw_pkg, the three channel interfaces and the driver RTL.
module rgbw_led_animation_driver_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rgbw_pkg::*;

  localparam int PHASE_STEPS   = 200;
  localparam int WAVE_LEN      = 3 * PHASE_STEPS;
  localparam int SETTLE_CYCLES = 16;
  localparam int STALL_LIMIT   = 3000;
  localparam int HOLD_CYCLES   = 300;
  localparam logic [2:0] COLOR_SEVEN = 3'd7;

  // Q30 angle constants for the cosine table
  localparam longint ANG_ONE     = 64'sd1073741824;
  localparam longint ANG_PI      = 64'sd3373259426;
  localparam longint ANG_HALF_PI = 64'sd1686629713;
  localparam longint ANG_TWO_PI  = 64'sd6746518852;

  logic clk;
  logic rst_n;

  rgbw_in_if  in_chan();
  rgbw_out_if out_chan();
  rgbw_cfg_if cfg_chan();

  rgbw_led_animation_driver #(.STEPS_PER_PERIOD(PHASE_STEPS)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  // predicted animation state and register copies
  mode_t       mode_reg;
  logic [2:0]  colour_reg;
  logic [9:0]  interval_reg;
  logic [31:0] due_time;
  logic [7:0]  phase;
  logic        white_held;
  int          cos_lut [WAVE_LEN];

  duty_t       pending_duties [$];
  logic [31:0] stamp;
  int          send_idle_pct;
  int          recv_stall_pct;
  int          hold_left;
  int          mismatches;
  int          quiet_cycles;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Q15 cosine of 2*pi*k/WAVE_LEN: first-quadrant Taylor series, clamped, rounded half up
  function automatic int cos_q15(input int k);
    longint ang;
    longint sq;
    longint acc;
    bit     flip;
    longint divs [6];
    divs = '{64'sd132, 64'sd90, 64'sd56, 64'sd30, 64'sd12, 64'sd2};
    flip = 1'b0;
    ang  = (longint'(k) * ANG_TWO_PI) / WAVE_LEN;
    if (ang > ANG_PI) begin
      ang = ANG_TWO_PI - ang;
    end
    if (ang > ANG_HALF_PI) begin
      ang  = ANG_PI - ang;
      flip = 1'b1;
    end
    sq  = (ang * ang) / ANG_ONE;
    acc = ANG_ONE;
    for (int i = 0; i < 6; i++) begin
      acc = ANG_ONE - ((sq * acc) / ANG_ONE) / divs[i];
    end
    if (acc < 0) begin
      acc = 0;
    end
    if (acc > ANG_ONE) begin
      acc = ANG_ONE;
    end
    acc = (acc + 64'sd16384) / 64'sd32768;
    return flip ? -int'(acc) : int'(acc);
  endfunction

  // full-scale levels of a colour, {red, green, blue, white}; code seven shows red
  function automatic logic [31:0] colour_levels(input logic [2:0] code);
    case (code)
      COLOR_YELLOW:  return {8'd255, 8'd255, 8'd0,   8'd0};
      COLOR_GREEN:   return {8'd0,   8'd255, 8'd0,   8'd0};
      COLOR_CYAN:    return {8'd0,   8'd255, 8'd255, 8'd0};
      COLOR_BLUE:    return {8'd0,   8'd0,   8'd255, 8'd0};
      COLOR_MAGENTA: return {8'd255, 8'd0,   8'd255, 8'd0};
      COLOR_WHITE:   return {8'd0,   8'd0,   8'd0,   8'd255};
      default:       return {8'd255, 8'd0,   8'd0,   8'd0};
    endcase
  endfunction

  function automatic logic [7:0] rainbow_level(input int k);
    int lvl;
    lvl = (255 * (cos_lut[k % WAVE_LEN] + 32768)) >>> 16;
    return 8'(lvl * 95 / 100);
  endfunction

  // advance the animation for one accepted timestamp and queue the duty word it causes
  function automatic void predict_duty(input logic [31:0] t);
    logic [31:0] lv;
    int          ch [4];
    int          duty [4];
    longint      gain;
    int          base;
    duty_t       d;
    if (t < due_time) begin
      return;
    end
    lv = colour_levels(colour_reg);
    ch[0] = lv[31:24];
    ch[1] = lv[23:16];
    ch[2] = lv[15:8];
    ch[3] = lv[7:0];
    if (mode_reg == MODE_SOLID || mode_reg == MODE_PULSE) begin
      white_held = (ch[3] != 0);
    end
    if (mode_reg == MODE_PULSE || mode_reg == MODE_RAINBOW) begin
      phase = (int'(phase) + 1 >= PHASE_STEPS) ? 8'd0 : phase + 8'd1;
    end
    base = 3 * int'(phase);
    case (mode_reg)
      MODE_SOLID: begin
        for (int i = 0; i < 4; i++) duty[i] = ch[i] * 95 / 100;
      end
      MODE_PULSE: begin
        gain = 47 * longint'(cos_lut[base % WAVE_LEN]) + 48 * 32768;
        for (int i = 0; i < 4; i++) duty[i] = int'((longint'(ch[i]) * gain) / (100 * 32768));
      end
      MODE_RAINBOW: begin
        duty[0] = rainbow_level(base);
        duty[1] = rainbow_level(base + 2 * PHASE_STEPS);
        duty[2] = rainbow_level(base + PHASE_STEPS);
        duty[3] = white_held ? 255 * 95 / 100 : 0;
      end
      default: begin
        for (int i = 0; i < 4; i++) duty[i] = 0;
        white_held = 1'b0;
      end
    endcase
    d.red   = 8'(duty[0]);
    d.green = 8'(duty[1]);
    d.blue  = 8'(duty[2]);
    d.white = 8'(duty[3]);
    pending_duties.push_back(d);
    due_time = t + 32'(interval_reg);
  endfunction

  // offer one timestamp word; valid stays high after acceptance until the next idle or pause
  task automatic send_stamp(input logic [31:0] t);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid  <= 1'b1;
    in_chan.now_ms <= t;
    do @(posedge clk); while (!in_chan.ready);
    predict_duty(t);
  endtask

  // stop offering, wait for every expected word, then let the block go quiet
  task automatic settle();
    in_chan.valid <= 1'b0;
    while (pending_duties.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [9:0] data);
    settle();
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data  <= data;
    do @(posedge clk); while (!cfg_chan.ready);
    cfg_chan.valid <= 1'b0;
    case (idx)
      REG_MODE:     mode_reg     = mode_t'(data[1:0]);
      REG_COLOR:    colour_reg   = data[2:0];
      REG_INTERVAL: interval_reg = data;
      default: ;
    endcase
  endtask

  // result checker
  always @(posedge clk) begin
    duty_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_duties.size() == 0) begin
        $error("unexpected duty word r=%0d g=%0d b=%0d w=%0d", out_chan.red_duty,
               out_chan.green_duty, out_chan.blue_duty, out_chan.white_duty);
        mismatches++;
      end else begin
        want = pending_duties.pop_front();
        if (out_chan.red_duty !== want.red) begin
          $error("red_duty expected %0d got %0d", want.red, out_chan.red_duty);
          mismatches++;
        end
        if (out_chan.green_duty !== want.green) begin
          $error("green_duty expected %0d got %0d", want.green, out_chan.green_duty);
          mismatches++;
        end
        if (out_chan.blue_duty !== want.blue) begin
          $error("blue_duty expected %0d got %0d", want.blue, out_chan.blue_duty);
          mismatches++;
        end
        if (out_chan.white_duty !== want.white) begin
          $error("white_duty expected %0d got %0d", want.white, out_chan.white_duty);
          mismatches++;
        end
      end
    end
  end

  // receiver: long hold-off when requested, otherwise random stalls
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_chan.ready <= 1'b0;
      hold_left--;
    end else begin
      out_chan.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // watchdog on cycles with no word moving on any channel
  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) ||
        (cfg_chan.valid && cfg_chan.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // defaults after reset, a stamp that is not yet due, then the due one
  task automatic test_reset_state();
    send_stamp(32'd0);
    send_stamp(32'd9);
    send_stamp(32'd10);
  endtask

  // every colour code in solid mode, code seven included
  task automatic test_colour_table();
    stamp = 32'd1000;
    for (int c = 0; c < 8; c++) begin
      write_reg(REG_COLOR, 10'(c));
      stamp += 32'd100;
      send_stamp(stamp);
    end
  endtask

  // pulse, rainbow with and without the held white level, off
  task automatic test_mode_sequence();
    write_reg(REG_COLOR, 10'(COLOR_YELLOW));
    write_reg(REG_MODE, 10'(MODE_PULSE));
    stamp += 32'd100;
    send_stamp(stamp);
    write_reg(REG_COLOR, 10'(COLOR_WHITE));
    stamp += 32'd100;
    send_stamp(stamp);
    write_reg(REG_MODE, 10'(MODE_RAINBOW));
    stamp += 32'd100;
    send_stamp(stamp);
    write_reg(REG_MODE, 10'(MODE_OFF));
    stamp += 32'd100;
    send_stamp(stamp);
    write_reg(REG_MODE, 10'(MODE_RAINBOW));
    stamp += 32'd100;
    send_stamp(stamp);
  endtask

  // zero interval, largest interval and the due time wrapping past the top
  task automatic test_interval_limits();
    write_reg(REG_INTERVAL, 10'd0);
    stamp += 32'd100;
    send_stamp(stamp);
    send_stamp(stamp);
    write_reg(REG_INTERVAL, 10'd1023);
    send_stamp(32'hFFFF_FF00);
    send_stamp(32'hFFFF_FFFF);
    send_stamp(32'd5);
    send_stamp(32'h0000_03FE);
    stamp = 32'h0000_03FE;
  endtask

  // receiver holds off while every stamp is due, so the block backs up into its input
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_reg(REG_MODE, 10'(MODE_PULSE));
    write_reg(REG_INTERVAL, 10'd0);
    hold_left = HOLD_CYCLES;
    for (int i = 0; i < 24; i++) begin
      stamp += 32'd1;
      send_stamp(stamp);
    end
    settle();
  endtask

  // random settings per segment, mostly advancing stamps with stale, repeated and wild ones
  task automatic test_random_traffic(input int idle_pct, input int stall_pct);
    int          pick;
    int          span;
    logic [31:0] t;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int seg = 0; seg < 8; seg++) begin
      write_reg(REG_MODE, 10'($urandom_range(0, 3)));
      write_reg(REG_COLOR, 10'($urandom_range(0, 7)));
      case ($urandom_range(0, 9))
        0:       write_reg(REG_INTERVAL, 10'd0);
        1:       write_reg(REG_INTERVAL, 10'd1);
        2:       write_reg(REG_INTERVAL, 10'd1023);
        3:       write_reg(REG_INTERVAL, 10'd1000);
        default: write_reg(REG_INTERVAL, 10'($urandom_range(2, 30)));
      endcase
      span = 2 * int'(interval_reg) + 2;
      for (int i = 0; i < 38; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 75) begin
          stamp += 32'($urandom_range(0, span));
          t = stamp;
        end else if (pick < 85) begin
          t = stamp - 32'($urandom_range(1, 50));
        end else if (pick < 92) begin
          t = stamp;
        end else if (pick < 96) begin
          stamp = $urandom;
          t = stamp;
        end else begin
          stamp = 32'hFFFF_FFFF - 32'($urandom_range(0, span + 2));
          t = stamp;
        end
        send_stamp(t);
      end
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_chan.valid  = 1'b0;
    in_chan.now_ms = '0;
    cfg_chan.valid = 1'b0;
    cfg_chan.index = '0;
    cfg_chan.data  = '0;
    out_chan.ready = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = 0;
    mismatches     = 0;
    quiet_cycles   = 0;
    stamp          = '0;
    mode_reg       = MODE_SOLID;
    colour_reg     = COLOR_RED;
    interval_reg   = INTERVAL_RESET;
    due_time       = '0;
    phase          = '0;
    white_held     = 1'b0;
    for (int k = 0; k < WAVE_LEN; k++) cos_lut[k] = cos_q15(k);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_colour_table();
    test_mode_sequence();
    test_interval_limits();
    test_backpressure();
    test_random_traffic(0, 0);
    test_random_traffic(51, 0);
    test_random_traffic(0, 51);
    test_random_traffic(8, 8);

    settle();
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
